[hdl/ahd_pkg.sv]
package ahd_pkg;

  // field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;

  // datapath step, one per controller state
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_NOW,
    OP_MUL_PREV,
    OP_MUL_BACK,
    OP_MUL_PEAK,
    OP_ROUND,
    OP_MIX_OLD,
    OP_MIX_NEW,
    OP_BASE,
    OP_DIFF,
    OP_FLAG,
    OP_OUT
  } op_t;

  // command from controller to datapath
  typedef struct packed {
    op_t op;
  } cmd_t;

endpackage

[hdl/ahd_ctrl.sv]
module ahd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          sample_invalid,
  output logic          s_tready,
  input  logic          m_tready,
  output logic          m_tvalid,
  output ahd_pkg::cmd_t cmd
);
  import ahd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_NOW,
    S_MUL_PREV,
    S_MUL_BACK,
    S_MUL_PEAK,
    S_ROUND,
    S_MIX_OLD,
    S_MIX_NEW,
    S_BASE,
    S_DIFF,
    S_FLAG,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // datapath step for the current state
  always_comb begin
    unique case (state)
      S_IDLE:     cmd.op = (s_tvalid && !sample_invalid) ? OP_LOAD : OP_NONE;
      S_MUL_NOW:  cmd.op = OP_MUL_NOW;
      S_MUL_PREV: cmd.op = OP_MUL_PREV;
      S_MUL_BACK: cmd.op = OP_MUL_BACK;
      S_MUL_PEAK: cmd.op = OP_MUL_PEAK;
      S_ROUND:    cmd.op = OP_ROUND;
      S_MIX_OLD:  cmd.op = OP_MIX_OLD;
      S_MIX_NEW:  cmd.op = OP_MIX_NEW;
      S_BASE:     cmd.op = OP_BASE;
      S_DIFF:     cmd.op = OP_DIFF;
      S_FLAG:     cmd.op = OP_FLAG;
      S_DONE:     cmd.op = out_free ? OP_OUT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  // sequencer and output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // valid set when the result word is loaded, cleared once it is taken
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= sample_invalid ? S_DONE : S_MUL_NOW;
          end
        end
        S_MUL_NOW:  state <= S_MUL_PREV;
        S_MUL_PREV: state <= S_MUL_BACK;
        S_MUL_BACK: state <= S_MUL_PEAK;
        S_MUL_PEAK: state <= S_ROUND;
        S_ROUND:    state <= S_MIX_OLD;
        S_MIX_OLD:  state <= S_MIX_NEW;
        S_MIX_NEW:  state <= S_BASE;
        S_BASE:     state <= S_DIFF;
        S_DIFF:     state <= S_FLAG;
        S_FLAG:     state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/ahd_dpath.sv]
module ahd_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  ahd_pkg::cmd_t                   cmd,
  input  logic                            cfg_we,
  input  logic [ahd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ahd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [ahd_pkg::SAMPLE_W-1:0]    sample,
  output logic [ahd_pkg::SAMPLE_W-1:0]    filtered,
  output logic                            is_high
);
  import ahd_pkg::*;

  localparam int COEF_W   = 18;
  localparam int WEIGHT_W = 17;
  localparam int LEVEL_W  = 16;
  localparam int X_W      = 15;
  localparam int PEAK_W   = 16;
  localparam int BASE_W   = 32;
  localparam int MA_W     = 33;
  localparam int MB_W     = 18;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int ACC_W    = 52;
  localparam int YW_W     = ACC_W - 16;
  localparam int DIFF_W   = BASE_W + 1;
  localparam int LIM_W    = 38;

  localparam logic [X_W-1:0]      SAMPLE_MAX = 15'd20480;
  localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'd65536;
  localparam logic [ACC_W-1:0]    HALF_LSB   = 52'd32768;
  localparam logic signed [YW_W-1:0] Y_MAX   = 36'sd32767;
  localparam logic signed [YW_W-1:0] Y_MIN   = -36'sd32768;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_FEED_NOW  = 3'd0,
    REG_COEF_FEED_PREV = 3'd1,
    REG_COEF_BACK_PREV = 3'd2,
    REG_BASELINE_W     = 3'd3,
    REG_PEAK_DECAY     = 3'd4,
    REG_LEVEL_LOW      = 3'd5,
    REG_LEVEL_HIGH     = 3'd6
  } reg_idx_t;

  // configuration
  logic signed [COEF_W-1:0]  coef_now, coef_prev, coef_back;
  logic [WEIGHT_W-1:0]       base_w, decay;
  logic signed [LEVEL_W-1:0] lvl_low, lvl_high;

  // state
  logic [X_W-1:0]            x_reg, last_input;
  logic signed [15:0]        last_filtered;
  logic signed [BASE_W-1:0]  baseline;
  logic [PEAK_W-1:0]         peak, peak_dec;
  logic                      high_flag;

  // working registers
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DIFF_W-1:0]  diff;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic [WEIGHT_W-1:0]       w_clamp, d_clamp, one_minus_w, one_minus_d;
  logic [X_W-1:0]            x_clamp;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [YW_W-1:0]    y_wide;
  logic signed [15:0]        y_sat;
  logic [16:0]               mag;
  logic [PEAK_W-1:0]         peak_up;
  logic signed [LEVEL_W-1:0] lvl_sel;
  logic signed [LIM_W-1:0]   lim, diff_x;

  // weight limits and sample clamp
  always_comb begin
    w_clamp     = (base_w > ONE_Q16) ? ONE_Q16 : base_w;
    d_clamp     = (decay > ONE_Q16) ? ONE_Q16 : decay;
    one_minus_w = ONE_Q16 - w_clamp;
    one_minus_d = ONE_Q16 - d_clamp;
    if (sample[SAMPLE_W-1]) begin
      x_clamp = '0;
    end else if (sample[X_W-1:0] > SAMPLE_MAX) begin
      x_clamp = SAMPLE_MAX;
    end else begin
      x_clamp = sample[X_W-1:0];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    lvl_sel = high_flag ? lvl_low : lvl_high;
    unique case (cmd.op)
      OP_MUL_NOW: begin
        mul_a = {{(MA_W-COEF_W){coef_now[COEF_W-1]}}, coef_now};
        mul_b = {{(MB_W-X_W){1'b0}}, x_reg};
      end
      OP_MUL_PREV: begin
        mul_a = {{(MA_W-COEF_W){coef_prev[COEF_W-1]}}, coef_prev};
        mul_b = {{(MB_W-X_W){1'b0}}, last_input};
      end
      OP_MUL_BACK: begin
        mul_a = {{(MA_W-COEF_W){coef_back[COEF_W-1]}}, coef_back};
        mul_b = {{(MB_W-16){last_filtered[15]}}, last_filtered};
      end
      OP_MUL_PEAK: begin
        mul_a = {{(MA_W-PEAK_W){1'b0}}, peak};
        mul_b = {{(MB_W-WEIGHT_W){1'b0}}, one_minus_d};
      end
      OP_ROUND: begin
        mul_a = {baseline[BASE_W-1], baseline};
        mul_b = {{(MB_W-WEIGHT_W){1'b0}}, one_minus_w};
      end
      OP_MIX_OLD: begin
        mul_a = {{(MA_W-16){last_filtered[15]}}, last_filtered};
        mul_b = {{(MB_W-WEIGHT_W){1'b0}}, w_clamp};
      end
      // level times peak, ready in the product register for the flag step
      OP_DIFF: begin
        mul_a = {{(MA_W-LEVEL_W){lvl_sel[LEVEL_W-1]}}, lvl_sel};
        mul_b = {{(MB_W-PEAK_W){1'b0}}, peak};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounding, saturation, peak raise and threshold
  always_comb begin
    acc_rnd = acc + HALF_LSB;
    y_wide  = acc_rnd[ACC_W-1:16];
    if (y_wide > Y_MAX) begin
      y_sat = 16'sh7fff;
    end else if (y_wide < Y_MIN) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_wide[15:0];
    end
    mag = last_filtered[15] ? (~{1'b1, last_filtered} + 17'd1) : {1'b0, last_filtered};
    peak_up = (mag[PEAK_W-1:0] > peak_dec) ? mag[PEAK_W-1:0] : peak_dec;
    lim     = {prod[MA_W-1:0], 5'b0};
    diff_x  = {{(LIM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_now  <= 18'sd65536;
      coef_prev <= '0;
      coef_back <= '0;
      base_w    <= 17'd655;
      decay     <= '0;
      lvl_low   <= 16'sd512;
      lvl_high  <= 16'sd1024;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF_FEED_NOW:  coef_now  <= cfg_data;
        REG_COEF_FEED_PREV: coef_prev <= cfg_data;
        REG_COEF_BACK_PREV: coef_back <= cfg_data;
        REG_BASELINE_W:     base_w    <= cfg_data[WEIGHT_W-1:0];
        REG_PEAK_DECAY:     decay     <= cfg_data[WEIGHT_W-1:0];
        REG_LEVEL_LOW:      lvl_low   <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_HIGH:     lvl_high  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_input    <= '0;
      last_filtered <= '0;
      baseline      <= '0;
      peak          <= 16'd1;
      high_flag     <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_ROUND: begin
          last_filtered <= y_sat;
          last_input    <= x_reg;
        end
        OP_MIX_OLD: peak <= (peak_up == '0) ? 16'd1 : peak_up;
        OP_BASE:    baseline <= acc_rnd[BASE_W+15:16];
        OP_FLAG: begin
          if (high_flag) begin
            if (diff_x < lim) high_flag <= 1'b0;
          end else begin
            if (diff_x > lim) high_flag <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and result word
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:     x_reg <= x_clamp;
      OP_MUL_PREV: acc <= {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      OP_MUL_BACK: acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      OP_MUL_PEAK: acc <= acc - {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      OP_ROUND:    peak_dec <= prod[31:16];
      OP_MIX_OLD:  acc <= {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      OP_MIX_NEW:  acc <= acc + {prod[ACC_W-17:0], 16'b0};
      OP_DIFF:     diff <= {last_filtered[15], last_filtered, 16'b0}
                           - {baseline[BASE_W-1], baseline};
      OP_OUT: begin
        filtered <= last_filtered;
        is_high  <= high_flag;
      end
      default: ;
    endcase
  end

endmodule

[hdl/adaptive_hysteresis_detector_unit.sv]
// Hysteresis detector on a low-passed, baseline-removed, peak-normalised
// sensor signal. A valid sample goes from acceptance to the next free
// slot at the input through ten datapath steps, built around one shared
// 33x18 multiplier that forms seven products in turn, plus the accept and
// result-load steps. An invalid sample skips the datapath steps and
// returns the last filtered value and flag. A finished result word waits
// in the output register while the next sample is taken. Configuration
// writes take effect at once and are meant for idle periods only.
module adaptive_hysteresis_detector_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ahd_pkg::SAMPLE_W-1:0]    s_tdata,  // sample
  input  logic                            s_tuser,  // sample_invalid
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ahd_pkg::SAMPLE_W-1:0]    m_tdata,  // filtered
  output logic                            m_tuser,  // is_high
  input  logic                            cfg_we,
  input  logic [ahd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ahd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ahd_pkg::*;

  cmd_t cmd;

  // sequencer
  ahd_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .sample_invalid (s_tuser),
    .s_tready       (s_tready),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .cmd            (cmd)
  );

  // arithmetic and state
  ahd_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .sample   (s_tdata),
    .filtered (m_tdata),
    .is_high  (m_tuser)
  );

`ifndef ASSERT_OFF
  // an accepted word makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a word");

  // the result register is loaded only when its slot is free
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

  // the filter sequence starts only from a latched sample
  a_filter_start: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_MUL_NOW |-> $past(cmd.op) == OP_LOAD)
    else $error("filter step without a loaded sample");

  // a loaded result shows as valid and the input reopens
  a_out_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |=> m_tvalid && s_tready)
    else $error("result load not followed by valid output");
`endif

endmodule
